@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/adel_pkg.sv @@
package adel_pkg;

  localparam int CFG_INDEX_W = 1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_BYTE   = 2'd2;

  localparam logic [1:0] FMT_NONE  = 2'd0;
  localparam logic [1:0] FMT_SHORT = 2'd1;
  localparam logic [1:0] FMT_LONG  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_BY_INDEX = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_INDEX    = 1'd1;

  localparam logic [15:0] MAGIC_SHORT     = 16'hC0FB;
  localparam logic [15:0] MAGIC_LONG_HEAD = 16'h4249;
  localparam logic [31:0] MAGIC_LONG      = 32'h42494746;
  localparam logic [31:0] SHORT_SIZE_ADJ  = 32'd4;
  localparam logic [31:0] LONG_SIZE_POS   = 32'hC;
  localparam logic [31:0] LONG_HDR_LAST   = 32'hF;

  typedef enum logic [5:0] {
    PH_MAGIC     = 6'b000001,
    PH_SHORT_HDR = 6'b000010,
    PH_LONG_HDR  = 6'b000100,
    PH_OFFSET    = 6'b001000,
    PH_SIZE      = 6'b010000,
    PH_NAME      = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  file_format;
    logic [31:0] entry_number;
    logic [31:0] entry_offset;
    logic [31:0] entry_size;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

@@ rtl/adel_ram.sv @@
module adel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/archive_directory_entry_locator.sv @@
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_ready    adel_pkg::item_t
// result    out        result_valid / result_ready adel_pkg::result_t
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item per cycle is accepted while no result is stalled; each passes an input
// register, is processed from there, and any result it yields is registered.
// The search name lives in a RAM with registered read that is prefetched at the
// next compare position, with a bypass for a character written the same cycle.
// Reset is synchronous and clears all control state; there is no clearing pass.
// A stalled result holds the pipeline; cfg_ready is always high.
module archive_directory_entry_locator #(
  parameter int NAME_MAX = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  adel_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output adel_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [adel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  localparam int AW  = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int LW  = $clog2(NAME_MAX + 1);
  localparam int CPW = (LW > 3) ? LW : 3;

  logic              search_by_index;
  logic [31:0]       target_index;

  logic              s1_valid;
  adel_pkg::item_t   s1_item;
  logic              adv;

  logic [LW-1:0]     search_length, search_length_next;
  logic              name_overflow, name_overflow_next;
  adel_pkg::phase_t  parse_phase, parse_phase_next;
  logic [31:0]       byte_position, byte_position_next;
  logic [31:0]       archive_end, archive_end_next;
  logic [31:0]       field_shift, field_shift_next;
  logic [31:0]       current_offset, current_offset_next;
  logic [31:0]       current_size, current_size_next;
  logic [31:0]       entry_counter, entry_counter_next;
  logic [CPW-1:0]    compare_position, compare_position_next;
  logic              name_mismatch, name_mismatch_next;
  logic [1:0]        format_kind, format_kind_next;
  logic              search_done, search_done_next;

  logic              emit;
  logic              hit;
  adel_pkg::result_t result_next;

  logic              name_we;
  logic [AW-1:0]     name_waddr;
  logic [AW-1:0]     name_raddr;
  logic [7:0]        ram_rdata;
  logic              bypass_valid;
  logic [7:0]        bypass_data;
  logic [7:0]        name_char;

  logic [31:0]       fs_shift;
  logic [CPW-1:0]    cp_inc;
  logic [CPW-1:0]    field_width;
  logic [CPW-1:0]    length_ext;
  logic              name_ends;
  logic              dir_done_hdr;
  logic              dir_done_cur;

  assign cfg_ready  = 1'b1;
  assign adv        = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_by_index <= 1'b0;
      target_index    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        adel_pkg::CFG_SEARCH_BY_INDEX: search_by_index <= cfg_data[0];
        adel_pkg::CFG_TARGET_INDEX:    target_index    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
  end

  adel_ram #(
    .WIDTH (8),
    .DEPTH (NAME_MAX)
  ) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (s1_item.data_byte),
    .raddr (name_raddr),
    .rdata (ram_rdata)
  );

  assign name_waddr = search_length[AW-1:0];
  assign name_raddr = compare_position_next[AW-1:0];
  assign name_char  = bypass_valid ? bypass_data : ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass_valid <= 1'b0;
    end else begin
      bypass_valid <= name_we && (name_waddr == name_raddr);
    end
  end

  always_ff @(posedge clk) begin
    bypass_data <= s1_item.data_byte;
  end

  assign fs_shift    = {field_shift[23:0], s1_item.data_byte};
  assign cp_inc      = compare_position + CPW'(1);
  assign field_width = (format_kind == adel_pkg::FMT_SHORT) ? CPW'(3) : CPW'(4);
  assign length_ext  = CPW'(search_length);
  assign name_ends   = (compare_position == length_ext) ||
                       ((compare_position < length_ext) && (name_char == 8'h00));
  assign dir_done_hdr = ({1'b0, byte_position} + 33'd1) >= {1'b0, fs_shift};
  assign dir_done_cur = ({1'b0, byte_position} + 33'd1) >= {1'b0, archive_end};

  always_comb begin
    search_length_next    = search_length;
    name_overflow_next    = name_overflow;
    parse_phase_next      = parse_phase;
    byte_position_next    = byte_position;
    archive_end_next      = archive_end;
    field_shift_next      = field_shift;
    current_offset_next   = current_offset;
    current_size_next     = current_size;
    entry_counter_next    = entry_counter;
    compare_position_next = compare_position;
    name_mismatch_next    = name_mismatch;
    format_kind_next      = format_kind;
    search_done_next      = search_done;
    emit                  = 1'b0;
    hit                   = 1'b0;
    name_we               = 1'b0;

    if (adv) begin
      case (s1_item.opcode)
        adel_pkg::OP_CLEAR: begin
          search_length_next    = '0;
          name_overflow_next    = 1'b0;
          parse_phase_next      = adel_pkg::PH_MAGIC;
          byte_position_next    = '0;
          archive_end_next      = '0;
          field_shift_next      = '0;
          current_offset_next   = '0;
          current_size_next     = '0;
          entry_counter_next    = '0;
          compare_position_next = '0;
          name_mismatch_next    = 1'b0;
          format_kind_next      = adel_pkg::FMT_NONE;
          search_done_next      = 1'b0;
        end
        adel_pkg::OP_APPEND: begin
          if (search_length < LW'(NAME_MAX)) begin
            name_we            = 1'b1;
            search_length_next = search_length + LW'(1);
          end else begin
            name_overflow_next = 1'b1;
          end
        end
        adel_pkg::OP_BYTE: begin
          if (!search_done) begin
            if (byte_position != 32'hFFFF_FFFF) begin
              byte_position_next = byte_position + 32'd1;
            end
            case (parse_phase)
              adel_pkg::PH_MAGIC: begin
                field_shift_next = fs_shift;
                if (byte_position == 32'd1) begin
                  if (fs_shift[15:0] == adel_pkg::MAGIC_SHORT) begin
                    format_kind_next = adel_pkg::FMT_SHORT;
                    parse_phase_next = adel_pkg::PH_SHORT_HDR;
                    field_shift_next = '0;
                  end else if (fs_shift[15:0] != adel_pkg::MAGIC_LONG_HEAD) begin
                    emit = 1'b1;
                  end
                end else if (byte_position >= 32'd3) begin
                  if (fs_shift == adel_pkg::MAGIC_LONG) begin
                    format_kind_next = adel_pkg::FMT_LONG;
                    parse_phase_next = adel_pkg::PH_LONG_HDR;
                    field_shift_next = '0;
                  end else begin
                    emit = 1'b1;
                  end
                end
              end
              adel_pkg::PH_SHORT_HDR: begin
                if (byte_position == 32'd2 || byte_position == 32'd3) begin
                  field_shift_next = fs_shift;
                end
                if (byte_position == 32'd3) begin
                  archive_end_next = {16'd0, fs_shift[15:0]} + adel_pkg::SHORT_SIZE_ADJ;
                end
                if (byte_position >= 32'd5) begin
                  if (dir_done_cur) begin
                    emit = 1'b1;
                  end else begin
                    parse_phase_next      = adel_pkg::PH_OFFSET;
                    compare_position_next = '0;
                    field_shift_next      = '0;
                  end
                end
              end
              adel_pkg::PH_LONG_HDR: begin
                if (byte_position >= adel_pkg::LONG_SIZE_POS) begin
                  field_shift_next = fs_shift;
                  if (byte_position >= adel_pkg::LONG_HDR_LAST) begin
                    archive_end_next = fs_shift;
                    if (dir_done_hdr) begin
                      emit = 1'b1;
                    end else begin
                      parse_phase_next      = adel_pkg::PH_OFFSET;
                      compare_position_next = '0;
                      field_shift_next      = '0;
                    end
                  end
                end
              end
              adel_pkg::PH_OFFSET, adel_pkg::PH_SIZE: begin
                field_shift_next      = fs_shift;
                compare_position_next = cp_inc;
                if (cp_inc >= field_width) begin
                  if (parse_phase == adel_pkg::PH_OFFSET) begin
                    current_offset_next   = fs_shift;
                    parse_phase_next      = adel_pkg::PH_SIZE;
                    compare_position_next = '0;
                    field_shift_next      = '0;
                  end else begin
                    current_size_next = fs_shift;
                    if (search_by_index && entry_counter == target_index) begin
                      emit = 1'b1;
                      hit  = 1'b1;
                    end else begin
                      parse_phase_next      = adel_pkg::PH_NAME;
                      compare_position_next = '0;
                      name_mismatch_next    = 1'b0;
                    end
                  end
                end
              end
              adel_pkg::PH_NAME: begin
                if (s1_item.data_byte == 8'h00) begin
                  if (!search_by_index && !name_overflow && !name_mismatch && name_ends) begin
                    emit = 1'b1;
                    hit  = 1'b1;
                  end else begin
                    entry_counter_next = entry_counter + 32'd1;
                    if (dir_done_cur) begin
                      emit = 1'b1;
                    end else begin
                      parse_phase_next      = adel_pkg::PH_OFFSET;
                      compare_position_next = '0;
                      field_shift_next      = '0;
                    end
                  end
                end else begin
                  if (compare_position >= length_ext ||
                      adel_pkg::fold_case(name_char) !=
                      adel_pkg::fold_case(s1_item.data_byte)) begin
                    name_mismatch_next = 1'b1;
                  end
                  if (compare_position < CPW'(NAME_MAX)) begin
                    compare_position_next = cp_inc;
                  end
                end
              end
              default: ;
            endcase
            if (s1_item.last_byte) begin
              emit = 1'b1;
            end
            if (emit) begin
              search_done_next = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result_next.found        = hit;
    result_next.file_format  = format_kind_next;
    result_next.entry_number = hit ? entry_counter : 32'd0;
    result_next.entry_offset = hit ? current_offset_next : 32'd0;
    result_next.entry_size   = hit ? current_size_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_length    <= '0;
      name_overflow    <= 1'b0;
      parse_phase      <= adel_pkg::PH_MAGIC;
      byte_position    <= '0;
      archive_end      <= '0;
      field_shift      <= '0;
      current_offset   <= '0;
      current_size     <= '0;
      entry_counter    <= '0;
      compare_position <= '0;
      name_mismatch    <= 1'b0;
      format_kind      <= adel_pkg::FMT_NONE;
      search_done      <= 1'b0;
    end else begin
      search_length    <= search_length_next;
      name_overflow    <= name_overflow_next;
      parse_phase      <= parse_phase_next;
      byte_position    <= byte_position_next;
      archive_end      <= archive_end_next;
      field_shift      <= field_shift_next;
      current_offset   <= current_offset_next;
      current_size     <= current_size_next;
      entry_counter    <= entry_counter_next;
      compare_position <= compare_position_next;
      name_mismatch    <= name_mismatch_next;
      format_kind      <= format_kind_next;
      search_done      <= search_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/adel_checker.sv @@
`include "assert_macros.svh"

module adel_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input adel_pkg::result_t result
);

  `ASSERT_CLK(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result), "Result changed while stalled.")

  `ASSERT_CLK(a_miss_zero, clk, rst, result_valid && !result.found |-> result.entry_number == 32'd0 && result.entry_offset == 32'd0 && result.entry_size == 32'd0, "A miss carries nonzero entry fields.")

  `ASSERT_CLK(a_hit_format, clk, rst, result_valid && result.found |-> result.file_format == adel_pkg::FMT_SHORT || result.file_format == adel_pkg::FMT_LONG, "A hit without a recognized format.")

  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !result_valid, "Result valid right after reset.")

endmodule

bind archive_directory_entry_locator adel_checker u_adel_checker (.*);

@@ verif/archive_directory_entry_locator_test.sv @@
`timescale 1ns / 100ps

module archive_directory_entry_locator_test;

  localparam int          NAME_LIMIT   = 64;
  localparam int          ITEM_GOAL    = 1500;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          PIPE_SETTLE  = 6;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [7:0]  CASE_EDGES [8] = '{8'h40, 8'h41, 8'h5A, 8'h5B,
                                              8'h60, 8'h61, 8'h7A, 8'h7B};

  logic                             clk;
  logic                             rst;
  logic                             item_valid;
  logic                             item_ready;
  adel_pkg::item_t                  item;
  logic                             result_valid;
  logic                             result_ready;
  adel_pkg::result_t                result;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [adel_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]                      cfg_data;

  archive_directory_entry_locator #(
    .NAME_MAX (NAME_LIMIT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Shadow copy of the locator state.
  bit                match_by_index;
  logic [31:0]       wanted_index;
  logic [7:0]        name_chars [NAME_LIMIT];
  int unsigned       name_len;
  bit                name_over;
  adel_pkg::phase_t  scan_phase;
  logic [31:0]       scan_pos;
  logic [31:0]       dir_end;
  logic [31:0]       field_acc;
  logic [31:0]       cur_offset;
  logic [31:0]       cur_size;
  logic [31:0]       entry_count;
  int unsigned       field_count;
  bit                name_miss;
  logic [1:0]        scan_fmt;
  bit                scan_done;

  adel_pkg::result_t pending_lookups [$];
  adel_pkg::result_t expected_lookup;
  logic [7:0]        arc [$];
  int                live_items;
  int                lookups_issued;
  int                mismatches;
  int                cycles;
  bit                pace_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("archive_directory_entry_locator_test NOT OK");
      $finish;
    end
  end

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic void restart_scan();
    scan_phase  = adel_pkg::PH_MAGIC;
    scan_pos    = '0;
    dir_end     = '0;
    field_acc   = '0;
    cur_offset  = '0;
    cur_size    = '0;
    entry_count = '0;
    field_count = 0;
    name_miss   = 1'b0;
    scan_fmt    = adel_pkg::FMT_NONE;
    scan_done   = 1'b0;
  endfunction

  function automatic bit finish_lookup(input bit hit, output adel_pkg::result_t res);
    res.found        = hit;
    res.file_format  = scan_fmt;
    res.entry_number = hit ? entry_count : '0;
    res.entry_offset = hit ? cur_offset : '0;
    res.entry_size   = hit ? cur_size : '0;
    scan_done        = 1'b1;
    return 1'b1;
  endfunction

  // Returns 1 when no further entry fits below the total size; otherwise the
  // scan moves on to the offset field of the next entry.
  function automatic bit directory_ends_at(input logic [31:0] pos);
    if ({1'b0, pos} + 33'd1 >= {1'b0, dir_end}) begin
      return 1'b1;
    end
    scan_phase  = adel_pkg::PH_OFFSET;
    field_count = 0;
    field_acc   = '0;
    return 1'b0;
  endfunction

  function automatic bit predict_lookup(input adel_pkg::item_t it,
                                        output adel_pkg::result_t res);
    logic [31:0] pos;
    int unsigned width;
    bit          ends;
    res = '0;
    case (it.opcode)
      adel_pkg::OP_CLEAR: begin
        live_items++;
        name_len  = 0;
        name_over = 1'b0;
        restart_scan();
        return 1'b0;
      end
      adel_pkg::OP_APPEND: begin
        live_items++;
        if (name_len < NAME_LIMIT) begin
          name_chars[name_len] = it.data_byte;
          name_len++;
        end else begin
          name_over = 1'b1;
        end
        return 1'b0;
      end
      adel_pkg::OP_BYTE: ;
      default: return 1'b0;
    endcase
    if (scan_done) begin
      return 1'b0;
    end
    live_items++;
    pos = scan_pos;
    if (scan_pos != 32'hFFFF_FFFF) begin
      scan_pos++;
    end
    width = (scan_fmt == adel_pkg::FMT_SHORT) ? 3 : 4;
    case (scan_phase)
      adel_pkg::PH_MAGIC: begin
        field_acc = {field_acc[23:0], it.data_byte};
        if (pos == 32'd1) begin
          if (field_acc[15:0] == adel_pkg::MAGIC_SHORT) begin
            scan_fmt   = adel_pkg::FMT_SHORT;
            scan_phase = adel_pkg::PH_SHORT_HDR;
            field_acc  = '0;
          end else if (field_acc[15:0] != adel_pkg::MAGIC_LONG_HEAD) begin
            return finish_lookup(1'b0, res);
          end
        end else if (pos >= 32'd3) begin
          if (field_acc == adel_pkg::MAGIC_LONG) begin
            scan_fmt   = adel_pkg::FMT_LONG;
            scan_phase = adel_pkg::PH_LONG_HDR;
            field_acc  = '0;
          end else begin
            return finish_lookup(1'b0, res);
          end
        end
      end
      adel_pkg::PH_SHORT_HDR: begin
        if (pos == 32'd2 || pos == 32'd3) begin
          field_acc = {field_acc[23:0], it.data_byte};
        end
        if (pos == 32'd3) begin
          dir_end = {16'h0, field_acc[15:0]} + adel_pkg::SHORT_SIZE_ADJ;
        end
        if (pos >= 32'd5 && directory_ends_at(pos)) begin
          return finish_lookup(1'b0, res);
        end
      end
      adel_pkg::PH_LONG_HDR: begin
        if (pos >= adel_pkg::LONG_SIZE_POS) begin
          field_acc = {field_acc[23:0], it.data_byte};
          if (pos >= adel_pkg::LONG_HDR_LAST) begin
            dir_end = field_acc;
            if (directory_ends_at(pos)) begin
              return finish_lookup(1'b0, res);
            end
          end
        end
      end
      adel_pkg::PH_OFFSET, adel_pkg::PH_SIZE: begin
        field_acc = {field_acc[23:0], it.data_byte};
        field_count++;
        if (field_count >= width) begin
          if (scan_phase == adel_pkg::PH_OFFSET) begin
            cur_offset  = field_acc;
            scan_phase  = adel_pkg::PH_SIZE;
            field_count = 0;
            field_acc   = '0;
          end else begin
            cur_size = field_acc;
            if (match_by_index && entry_count == wanted_index) begin
              return finish_lookup(1'b1, res);
            end
            scan_phase  = adel_pkg::PH_NAME;
            field_count = 0;
            name_miss   = 1'b0;
          end
        end
      end
      adel_pkg::PH_NAME: begin
        if (it.data_byte == 8'h00) begin
          ends = (field_count == name_len) ||
                 (field_count < name_len && name_chars[field_count] == 8'h00);
          if (!match_by_index && !name_over && !name_miss && ends) begin
            return finish_lookup(1'b1, res);
          end
          entry_count++;
          if (directory_ends_at(pos)) begin
            return finish_lookup(1'b0, res);
          end
        end else begin
          if (field_count >= name_len ||
              to_lower(name_chars[field_count]) != to_lower(it.data_byte)) begin
            name_miss = 1'b1;
          end
          if (field_count < NAME_LIMIT) begin
            field_count++;
          end
        end
      end
      default: ;
    endcase
    if (it.last_byte) begin
      return finish_lookup(1'b0, res);
    end
    return 1'b0;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s: expected %h, got %h", field, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_ready === 1'b1) begin
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result transaction: %p", result);
        end
      end else begin
        expected_lookup = pending_lookups.pop_front();
        check_field("found", 32'(expected_lookup.found), 32'(result.found));
        check_field("file_format", 32'(expected_lookup.file_format),
                    32'(result.file_format));
        check_field("entry_number", expected_lookup.entry_number, result.entry_number);
        check_field("entry_offset", expected_lookup.entry_offset, result.entry_offset);
        check_field("entry_size", expected_lookup.entry_size, result.entry_size);
      end
    end
  end

  initial begin : result_backpressure
    int stall;
    result_ready = 1'b0;
    forever begin
      stall = pace_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid === 1'b1 && result_ready === 1'b1));
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input bit last);
    adel_pkg::item_t   it;
    adel_pkg::result_t res;
    int                gap;
    it.opcode    = op;
    it.data_byte = b;
    it.last_byte = last;
    gap = pace_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_ready !== 1'b1);
    if (predict_lookup(it, res)) begin
      pending_lookups.push_back(res);
      lookups_issued++;
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [adel_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == adel_pkg::CFG_SEARCH_BY_INDEX) begin
      match_by_index = value[0];
    end else begin
      wanted_index = value;
    end
  endtask

  task automatic load_name(input string s);
    send_item(adel_pkg::OP_CLEAR, 8'h00, 1'b0);
    foreach (s[i]) begin
      send_item(adel_pkg::OP_APPEND, s[i], 1'b0);
    end
  endtask

  function automatic void put_be(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      arc.push_back(v[8*i +: 8]);
    end
  endfunction

  function automatic void put_text(input string s);
    foreach (s[i]) begin
      arc.push_back(s[i]);
    end
    arc.push_back(8'h00);
  endfunction

  function automatic void start_archive(input logic [1:0] fmt);
    arc.delete();
    if (fmt == adel_pkg::FMT_SHORT) begin
      put_be({16'h0, adel_pkg::MAGIC_SHORT}, 2);
      put_be(32'h0, 4);
    end else begin
      put_be(adel_pkg::MAGIC_LONG, 4);
      put_be(32'h0, 4);
      put_be(32'h0, 4);
      put_be(32'h0, 4);
    end
  endfunction

  function automatic logic [31:0] exact_size();
    return (arc[0] == adel_pkg::MAGIC_SHORT[15:8]) ? 32'(arc.size() - 4)
                                                   : 32'(arc.size());
  endfunction

  function automatic void set_size_field(input logic [31:0] v);
    if (arc[0] == adel_pkg::MAGIC_SHORT[15:8]) begin
      arc[2] = v[15:8];
      arc[3] = v[7:0];
    end else begin
      for (int i = 0; i < 4; i++) begin
        arc[12 + i] = v[31 - 8*i -: 8];
      end
    end
  endfunction

  task automatic send_archive(input bit mark_last);
    foreach (arc[i]) begin
      send_item(adel_pkg::OP_BYTE, arc[i], mark_last && i == arc.size() - 1);
    end
  endtask

  function automatic logic [7:0] random_char(input bit allow_nul);
    logic [7:0] c;
    case ($urandom_range(0, 15))
      0: c = allow_nul ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 255));
      1: c = CASE_EDGES[$urandom_range(0, 7)];
      2: c = (allow_nul && $urandom_range(0, 3) == 0) ? 8'h00 : 8'h2E;
      default: begin
        c = 8'h61 + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) begin
          c = c ^ 8'h20;
        end
      end
    endcase
    return c;
  endfunction

  function automatic logic [31:0] field_value();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Fills every name slot once, then shows that a name past the limit never
  // matches, not even an entry equal to the characters that were kept.
  task automatic test_name_overflow();
    send_item(adel_pkg::OP_CLEAR, 8'h00, 1'b0);
    for (int i = 0; i < NAME_LIMIT + 2; i++) begin
      send_item(adel_pkg::OP_APPEND, 8'(8'h61 + i % 26), 1'b0);
    end
    start_archive(adel_pkg::FMT_SHORT);
    put_be(32'h0, 3);
    put_be(32'h0, 3);
    for (int i = 0; i < NAME_LIMIT; i++) begin
      arc.push_back(8'(8'h61 + i % 26));
    end
    arc.push_back(8'h00);
    set_size_field(exact_size());
    send_archive(1'b1);
  endtask

  task automatic test_short_name_match();
    load_name("rEAdMe");
    start_archive(adel_pkg::FMT_SHORT);
    put_be(32'hFF_FFFF, 3);
    put_be(32'h0, 3);
    put_text("read");
    put_be(32'h12_3456, 3);
    put_be(32'hFF_FFFF, 3);
    put_text("README");
    set_size_field(exact_size());
    send_archive(1'b1);
  endtask

  task automatic test_index_mode();
    write_cfg(adel_pkg::CFG_SEARCH_BY_INDEX, 32'h1);
    write_cfg(adel_pkg::CFG_TARGET_INDEX, 32'h1);
    load_name("x");
    start_archive(adel_pkg::FMT_LONG);
    put_be(32'hFFFF_FFFF, 4);
    put_be(32'h0, 4);
    put_text("x");
    put_be(32'h0, 4);
    put_be(32'hFFFF_FFFF, 4);
    put_text("y");
    set_size_field(exact_size());
    send_archive(1'b1);
    drain();
    write_cfg(adel_pkg::CFG_TARGET_INDEX, 32'hFFFF_FFFF);
    send_item(adel_pkg::OP_CLEAR, 8'hFF, 1'b1);
    send_archive(1'b1);
    drain();
    write_cfg(adel_pkg::CFG_SEARCH_BY_INDEX, 32'hFFFF_FFFE);
    write_cfg(adel_pkg::CFG_TARGET_INDEX, 32'h0);
  endtask

  task automatic test_bad_magic();
    send_item(adel_pkg::OP_CLEAR, 8'h00, 1'b0);
    arc = '{8'hC0, 8'hFA, 8'h55, 8'hAA};
    send_archive(1'b1);
    send_item(OP_UNUSED, 8'hFF, 1'b1);
    send_item(adel_pkg::OP_CLEAR, 8'h00, 1'b0);
    arc = '{8'h42, 8'h58};
    send_archive(1'b0);
    send_item(adel_pkg::OP_CLEAR, 8'h00, 1'b0);
    arc = '{8'h42, 8'h49, 8'h47, 8'h47};
    send_archive(1'b0);
  endtask

  task automatic test_directory_end();
    send_item(adel_pkg::OP_CLEAR, 8'h00, 1'b0);
    start_archive(adel_pkg::FMT_SHORT);
    set_size_field(32'h0);
    send_archive(1'b0);
    send_item(adel_pkg::OP_CLEAR, 8'h00, 1'b0);
    start_archive(adel_pkg::FMT_LONG);
    send_archive(1'b0);
    load_name("Z");
    start_archive(adel_pkg::FMT_LONG);
    put_be(32'h1, 4);
    put_be(32'h2, 4);
    put_text("zz");
    set_size_field(32'hFFFF_FFFF);
    send_archive(1'b1);
  endtask

  task automatic test_name_edits();
    send_item(adel_pkg::OP_CLEAR, 8'h00, 1'b0);
    send_item(adel_pkg::OP_APPEND, 8'h41, 1'b0);
    send_item(adel_pkg::OP_APPEND, 8'h00, 1'b0);
    send_item(adel_pkg::OP_APPEND, 8'h71, 1'b0);
    start_archive(adel_pkg::FMT_SHORT);
    put_be(32'h5, 3);
    put_be(32'h6, 3);
    put_text("a");
    set_size_field(exact_size());
    send_archive(1'b1);
    // The name grows while the entry name is being compared.
    load_name("a");
    start_archive(adel_pkg::FMT_LONG);
    put_be(32'h7, 4);
    put_be(32'h9, 4);
    put_text("aBc");
    set_size_field(exact_size());
    foreach (arc[i]) begin
      send_item(adel_pkg::OP_BYTE, arc[i], i == arc.size() - 1);
      if (i == 24) begin
        send_item(adel_pkg::OP_APPEND, 8'h62, 1'b1);
      end else if (i == 25) begin
        send_item(adel_pkg::OP_APPEND, 8'h43, 1'b0);
      end
    end
  endtask

  task automatic run_random_search();
    logic [7:0] name_q [$];
    logic [7:0] c;
    logic [1:0] fmt;
    logic [31:0] total;
    int         len, width, pick, last_mode, cut, tail;
    bit         last;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(NAME_LIMIT + 1, NAME_LIMIT + 6)
                                       : $urandom_range(0, 6);
    send_item(adel_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    for (int i = 0; i < len; i++) begin
      c = random_char(1'b1);
      name_q.push_back(c);
      send_item(adel_pkg::OP_APPEND, c, 1'($urandom_range(0, 1)));
    end
    pick = $urandom_range(0, 9);
    if (pick == 9) begin
      arc.delete();
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 2))
          0: arc.push_back(adel_pkg::MAGIC_LONG[31 - 8*k -: 8]);
          1: arc.push_back(k < 2 ? adel_pkg::MAGIC_SHORT[15 - 8*k -: 8] : 8'h00);
          default: arc.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      repeat ($urandom_range(0, 4)) arc.push_back(8'($urandom_range(0, 255)));
    end else begin
      fmt   = (pick < 5) ? adel_pkg::FMT_SHORT : adel_pkg::FMT_LONG;
      width = (fmt == adel_pkg::FMT_SHORT) ? 3 : 4;
      start_archive(fmt);
      repeat ($urandom_range(0, 4)) begin
        put_be(field_value(), width);
        put_be(field_value(), width);
        if ($urandom_range(0, 2) == 0) begin
          for (int i = 0; i < name_q.size() && name_q[i] != 8'h00; i++) begin
            c = name_q[i];
            if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1) == 1) begin
              c = c ^ 8'h20;
            end
            arc.push_back(c);
          end
          if ($urandom_range(0, 5) == 0) begin
            arc.push_back(random_char(1'b0));
          end
        end else begin
          repeat ($urandom_range(0, 6)) arc.push_back(random_char(1'b0));
        end
        arc.push_back(8'h00);
      end
      total = exact_size();
      case ($urandom_range(0, 9))
        0: total = field_value();
        1: total = total - $urandom_range(1, 12);
        2: total = total + $urandom_range(1, 30);
        default: ;
      endcase
      set_size_field(total);
    end
    last_mode = $urandom_range(0, 9);
    cut       = $urandom_range(0, arc.size() - 1);
    tail      = $urandom_range(0, 2);
    foreach (arc[i]) begin
      if (scan_done) begin
        if (tail == 0) begin
          break;
        end
        tail--;
      end
      case ($urandom_range(0, 99))
        0, 1, 2: send_item(adel_pkg::OP_APPEND, random_char(1'b1),
                           1'($urandom_range(0, 1)));
        3: send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        4: begin
          if ($urandom_range(0, 1) == 1) begin
            send_item(adel_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
          end
        end
        default: ;
      endcase
      if (last_mode <= 6) begin
        last = (i == arc.size() - 1);
      end else if (last_mode == 7) begin
        last = (i == cut);
      end else if (last_mode == 8) begin
        last = 1'b0;
      end else begin
        last = ($urandom_range(0, 19) == 0);
      end
      send_item(adel_pkg::OP_BYTE, arc[i], last);
      if (last_mode == 7 && i == cut) begin
        break;
      end
    end
  endtask

  task automatic test_random_directories();
    logic [31:0] target;
    while (live_items < ITEM_GOAL || lookups_issued < 60) begin
      drain();
      pace_on = ($urandom_range(0, 3) != 0);
      write_cfg(adel_pkg::CFG_SEARCH_BY_INDEX,
                ($urandom() & 32'hFFFF_FFFE) | 32'($urandom_range(0, 9) < 4));
      case ($urandom_range(0, 9))
        0: target = 32'h0;
        1: target = 32'hFFFF_FFFF;
        2: target = $urandom();
        default: target = $urandom_range(0, 4);
      endcase
      write_cfg(adel_pkg::CFG_TARGET_INDEX, target);
      repeat (8) run_random_search();
    end
  endtask

  initial begin
    rst            = 1'b1;
    item_valid     = 1'b0;
    item           = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    pace_on        = 1'b1;
    cycles         = 0;
    mismatches     = 0;
    live_items     = 0;
    lookups_issued = 0;
    match_by_index = 1'b0;
    wanted_index   = '0;
    name_len       = 0;
    name_over      = 1'b0;
    restart_scan();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_name_overflow();
    test_short_name_match();
    drain();
    test_index_mode();
    pace_on = 1'b0;
    test_bad_magic();
    test_directory_end();
    pace_on = 1'b1;
    test_name_edits();
    test_random_directories();

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("archive_directory_entry_locator_test OK");
    end else begin
      $display("archive_directory_entry_locator_test NOT OK");
    end
    $finish;
  end

endmodule
